/* rtl/psu_pkg.sv */
// Package for the particle store update block.
// Holds the command and entry types, the sequencer states and the status codes.
// No dependencies.
package psu_pkg;

  localparam int unsigned MaxEntriesDefault = 64;
  localparam int unsigned CountW = 7;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    STAT_ADDED   = 2'd0,
    STAT_DROPPED = 2'd1,
    STAT_ENTRY   = 2'd2,
    STAT_NONE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_TICK = 2'd1,
    CMD_SKIP = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [23:0] color;
    logic [15:0] size;
    logic [15:0] shader;
    logic [23:0] life;
    logic [23:0] init;
  } entry_t;

  typedef struct packed {
    cmd_kind_e   kind;
    entry_t      ent;
    logic [15:0] dt;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_SKIP,
    ST_P1_RD,
    ST_P1_MUL,
    ST_P1_WB,
    ST_EMPTY,
    ST_P2_RD,
    ST_P2_LD,
    ST_P2_DIV,
    ST_P2_OUT
  } state_e;

endpackage

/* rtl/psu_front.sv */
// Front end of the particle store update block: accepts input items,
// classifies them into add, tick and skipped tick, and queues them.
// Depends on psu_pkg.
module psu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            req_type_i,
  input  logic [31:0]     pos_x_i,
  input  logic [31:0]     pos_y_i,
  input  logic [31:0]     pos_z_i,
  input  logic [31:0]     vel_x_i,
  input  logic [31:0]     vel_y_i,
  input  logic [31:0]     vel_z_i,
  input  logic [23:0]     color_rgb_i,
  input  logic [15:0]     sprite_size_i,
  input  logic [23:0]     life_time_i,
  input  logic [15:0]     shader_handle_i,
  input  logic [15:0]     time_step_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output psu_pkg::cmd_t   cmd_o
);
  import psu_pkg::*;

  cmd_t       slot_q [QueueDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_in;
  logic       push, pop;

  always_comb begin
    cmd_in.ent.pos_x  = pos_x_i;
    cmd_in.ent.pos_y  = pos_y_i;
    cmd_in.ent.pos_z  = pos_z_i;
    cmd_in.ent.vel_x  = vel_x_i;
    cmd_in.ent.vel_y  = vel_y_i;
    cmd_in.ent.vel_z  = vel_z_i;
    cmd_in.ent.color  = color_rgb_i;
    cmd_in.ent.size   = sprite_size_i;
    cmd_in.ent.shader = shader_handle_i;
    cmd_in.ent.life   = life_time_i;
    cmd_in.ent.init   = life_time_i;
    cmd_in.dt         = time_step_i;
    priority if (!req_type_i) begin
      cmd_in.kind = CMD_ADD;
    end else if (time_step_i == 16'd0) begin
      cmd_in.kind = CMD_SKIP;
    end else begin
      cmd_in.kind = CMD_TICK;
    end
  end

  assign in_ready_o  = (cnt_q != 2'(QueueDepth));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= cmd_in;
  end

endmodule

/* rtl/psu_div.sv */
// Alpha unit: floor(255 * life / init), clamped to 255, one quotient bit per cycle.
// Depends on psu_pkg only by convention; it uses no package items.
module psu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] life_i,
  input  logic [23:0] init_i,
  output logic        busy_o,
  output logic [7:0]  alpha_o
);

  logic [23:0] rem_q;
  logic [7:0]  num_q;
  logic [7:0]  quo_q;
  logic [23:0] den_q;
  logic [3:0]  cnt_q;
  logic        busy_q;
  logic [31:0] num;
  logic [24:0] trial;
  logic        ge;

  assign num     = {life_i, 8'd0} - {8'd0, life_i};
  assign trial   = {rem_q, num_q[7]};
  assign ge      = (trial >= {1'b0, den_q});
  assign busy_o  = busy_q;
  assign alpha_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else if (start_i) begin
      // A zero initial life and a ratio of one or more both give full alpha.
      busy_q <= (init_i != 24'd0) && (num < {init_i, 8'd0});
      cnt_q  <= 4'd8;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 4'd1;
      busy_q <= (cnt_q != 4'd1);
    end
  end

  // The partial remainder stays below the divisor, so 24 bits hold it.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num[31:8];
      num_q <= num[7:0];
      den_q <= init_i;
      quo_q <= (init_i == 24'd0 || num >= {init_i, 8'd0}) ? 8'hFF : 8'd0;
    end else if (busy_q) begin
      rem_q <= ge ? 24'(trial - {1'b0, den_q}) : trial[23:0];
      num_q <= {num_q[6:0], 1'b0};
      quo_q <= {quo_q[6:0], ge};
    end
  end

endmodule

/* rtl/psu_back.sv */
// Back end of the particle store update block: the entry memory, the
// update-and-compact pass, the emit pass and the output register.
// Depends on psu_pkg and psu_div.
module psu_back #(
  parameter int unsigned MAX_ENTRIES = psu_pkg::MaxEntriesDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  output logic                      cmd_ready_o,
  input  psu_pkg::cmd_t             cmd_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [31:0]               out_pos_x_o,
  output logic [31:0]               out_pos_y_o,
  output logic [31:0]               out_pos_z_o,
  output logic [23:0]               out_color_rgb_o,
  output logic [15:0]               out_size_o,
  output logic [7:0]                out_alpha_o,
  output logic [15:0]               out_shader_o,
  output logic                      last_o,
  output logic [psu_pkg::CountW-1:0] live_count_o
);
  import psu_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  state_e state_q, state_d;
  cmd_t   cmd_q;
  logic [CountW-1:0] held_q, held_d, idx_q, idx_d, wr_q, wr_d;

  entry_t mem [MAX_ENTRIES];
  entry_t rdata_q, ent_q, wdata;
  logic   we;
  logic [AW-1:0] raddr, waddr;

  logic signed [48:0] prod_q [3];
  logic        surv_q;
  logic [31:0] new_pos [3];

  logic        div_start, div_busy;
  logic [7:0]  div_alpha;

  logic        out_free, emit, full;
  logic [1:0]  e_status;
  logic        e_last, e_use_ent;
  logic [CountW-1:0] e_live;

  assign out_free = !out_valid_o || out_ready_i;
  assign full     = (held_q >= CountW'(MAX_ENTRIES));

  psu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .life_i  (rdata_q.life),
    .init_i  (rdata_q.init),
    .busy_o  (div_busy),
    .alpha_o (div_alpha)
  );

  // Position update: delta is floor(prod / 65536), then saturate to 32 bits.
  always_comb begin
    logic [31:0] pos [3];
    logic signed [33:0] sum;
    pos[0] = ent_q.pos_x;
    pos[1] = ent_q.pos_y;
    pos[2] = ent_q.pos_z;
    for (int k = 0; k < 3; k++) begin
      sum = $signed({{2{pos[k][31]}}, pos[k]}) +
            $signed({prod_q[k][48], prod_q[k][48:16]});
      if (sum > 34'sh0_7FFF_FFFF) begin
        new_pos[k] = 32'h7FFF_FFFF;
      end else if (sum < -34'sh0_8000_0000) begin
        new_pos[k] = 32'h8000_0000;
      end else begin
        new_pos[k] = sum[31:0];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    held_d  = held_q;
    idx_d   = idx_q;
    wr_d    = wr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          idx_d = '0;
          wr_d  = '0;
          unique case (cmd_i.kind)
            CMD_ADD:  state_d = ST_ADD;
            CMD_SKIP: state_d = ST_SKIP;
            default:  state_d = ST_P1_RD;
          endcase
        end
      end
      ST_ADD: begin
        if (out_free) begin
          state_d = ST_IDLE;
          if (!full) held_d = held_q + 1'b1;
        end
      end
      ST_SKIP:  if (out_free) state_d = ST_IDLE;
      ST_EMPTY: if (out_free) state_d = ST_IDLE;
      ST_P1_RD: begin
        if (idx_q == held_q) begin
          held_d  = wr_q;
          idx_d   = '0;
          state_d = (wr_q == '0) ? ST_EMPTY : ST_P2_RD;
        end else begin
          state_d = ST_P1_MUL;
        end
      end
      ST_P1_MUL: state_d = ST_P1_WB;
      ST_P1_WB: begin
        idx_d   = idx_q + 1'b1;
        if (surv_q) wr_d = wr_q + 1'b1;
        state_d = ST_P1_RD;
      end
      ST_P2_RD:  state_d = ST_P2_LD;
      ST_P2_LD:  state_d = ST_P2_DIV;
      ST_P2_DIV: if (!div_busy) state_d = ST_P2_OUT;
      ST_P2_OUT: begin
        if (out_free) begin
          idx_d   = idx_q + 1'b1;
          state_d = (idx_q + 1'b1 == held_q) ? ST_IDLE : ST_P2_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready_o = (state_q == ST_IDLE);
    div_start   = (state_q == ST_P2_LD);
    raddr       = idx_q[AW-1:0];
    we          = 1'b0;
    waddr       = wr_q[AW-1:0];
    wdata       = ent_q;
    emit        = 1'b0;
    e_status    = STAT_NONE;
    e_last      = 1'b1;
    e_live      = held_q;
    e_use_ent   = 1'b0;
    unique case (state_q)
      ST_ADD: begin
        emit     = out_free;
        e_status = full ? STAT_DROPPED : STAT_ADDED;
        e_live   = full ? held_q : held_q + 1'b1;
        we       = out_free && !full;
        waddr    = held_q[AW-1:0];
        wdata    = cmd_q.ent;
      end
      ST_SKIP: emit = out_free;
      ST_EMPTY: begin
        emit   = out_free;
        e_live = '0;
      end
      ST_P1_WB: begin
        we           = surv_q;
        wdata.pos_x  = new_pos[0];
        wdata.pos_y  = new_pos[1];
        wdata.pos_z  = new_pos[2];
        wdata.life   = ent_q.life - {8'd0, cmd_q.dt};
      end
      ST_P2_OUT: begin
        emit      = out_free;
        e_status  = STAT_ENTRY;
        e_last    = (idx_q + 1'b1 == held_q);
        e_use_ent = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      idx_q       <= '0;
      wr_q        <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      idx_q   <= idx_d;
      wr_q    <= wr_d;
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
    if (state_q == ST_IDLE && cmd_valid_i) cmd_q <= cmd_i;
    if (state_q == ST_P1_MUL) begin
      ent_q     <= rdata_q;
      surv_q    <= (rdata_q.life > {8'd0, cmd_q.dt});
      prod_q[0] <= $signed(rdata_q.vel_x) * $signed({1'b0, cmd_q.dt});
      prod_q[1] <= $signed(rdata_q.vel_y) * $signed({1'b0, cmd_q.dt});
      prod_q[2] <= $signed(rdata_q.vel_z) * $signed({1'b0, cmd_q.dt});
    end
    if (state_q == ST_P2_LD) ent_q <= rdata_q;
    if (emit) begin
      status_o        <= e_status;
      last_o          <= e_last;
      live_count_o    <= e_live;
      out_pos_x_o     <= e_use_ent ? ent_q.pos_x : 32'd0;
      out_pos_y_o     <= e_use_ent ? ent_q.pos_y : 32'd0;
      out_pos_z_o     <= e_use_ent ? ent_q.pos_z : 32'd0;
      out_color_rgb_o <= e_use_ent ? ent_q.color : 24'd0;
      out_size_o      <= e_use_ent ? ent_q.size : 16'd0;
      out_shader_o    <= e_use_ent ? ent_q.shader : 16'd0;
      out_alpha_o     <= e_use_ent ? div_alpha : 8'd0;
    end
  end

endmodule

/* rtl/particle_store_update_core.sv */
// Top level of the particle store update block.
// Depends on psu_pkg, psu_front and psu_back.
//
// Usage: items enter on the in channel (valid/ready) and results leave on the
// out channel (valid/ready). An add item stores one particle, or reports a
// drop when the store holds MAX_ENTRIES particles, and gives one result. A
// tick with a zero step gives one result and leaves the store alone. A tick
// with a nonzero step updates every held particle, removes the expired ones,
// compacts the rest in order and then emits one result per survivor, the last
// one flagged, or one empty result when nothing survives.
// Timing: the front queue takes up to two items while the back end works.
// A tick reads each held particle in turn for the update pass, through the single
// memory read port and the registered multiply, and then handles each survivor
// in turn for the emit pass, through the bit-serial alpha divider.
// Reset empties the store and the queue; no clearing pass is needed.
// A stall on the out side holds the back end at its next result while the
// front queue keeps accepting until it is full.
module particle_store_update_core #(
  parameter int unsigned MAX_ENTRIES = psu_pkg::MaxEntriesDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      req_type_i,
  input  logic signed [31:0]        pos_x_i,
  input  logic signed [31:0]        pos_y_i,
  input  logic signed [31:0]        pos_z_i,
  input  logic signed [31:0]        vel_x_i,
  input  logic signed [31:0]        vel_y_i,
  input  logic signed [31:0]        vel_z_i,
  input  logic [23:0]               color_rgb_i,
  input  logic [15:0]               sprite_size_i,
  input  logic [23:0]               life_time_i,
  input  logic [15:0]               shader_handle_i,
  input  logic [15:0]               time_step_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic signed [31:0]        out_pos_x_o,
  output logic signed [31:0]        out_pos_y_o,
  output logic signed [31:0]        out_pos_z_o,
  output logic [23:0]               out_color_rgb_o,
  output logic [15:0]               out_size_o,
  output logic [7:0]                out_alpha_o,
  output logic [15:0]               out_shader_o,
  output logic                      last_o,
  output logic [psu_pkg::CountW-1:0] live_count_o
);
  import psu_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  psu_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .vel_x_i         (vel_x_i),
    .vel_y_i         (vel_y_i),
    .vel_z_i         (vel_z_i),
    .color_rgb_i     (color_rgb_i),
    .sprite_size_i   (sprite_size_i),
    .life_time_i     (life_time_i),
    .shader_handle_i (shader_handle_i),
    .time_step_i     (time_step_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_ready_i     (cmd_ready),
    .cmd_o           (cmd)
  );

  psu_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_ready_o     (cmd_ready),
    .cmd_i           (cmd),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .out_pos_x_o     (out_pos_x_o),
    .out_pos_y_o     (out_pos_y_o),
    .out_pos_z_o     (out_pos_z_o),
    .out_color_rgb_o (out_color_rgb_o),
    .out_size_o      (out_size_o),
    .out_alpha_o     (out_alpha_o),
    .out_shader_o    (out_shader_o),
    .last_o          (last_o),
    .live_count_o    (live_count_o)
  );

  // The store never reports more particles than it can hold.
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (live_count_o <= CountW'(MAX_ENTRIES)))
    else $error("live count above capacity");

  // Add, drop and STAT_NONE (skipped or empty tick) results are always the only result of their item.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_ADDED || status_o == STAT_DROPPED ||
     status_o == STAT_NONE)) |-> last_o)
    else $error("single result without last flag");

  // A survivor result implies a nonempty store.
  a_entry_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_ENTRY) |-> (live_count_o != '0))
    else $error("survivor result with empty store");

endmodule
